[design/rsam_pkg.sv]
package rsam_pkg;

	localparam int ADDR_W = 48;
	localparam int ELEM_W = 13;
	localparam int DISK_W = 8;
	localparam int LBA_W = 56;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_WIDTH_DEF = 16;
	localparam int BACKEND_BLOCKS_DEF = 1024;

	localparam logic [ELEM_W-1:0] ELEM_RESET = 13'd128;
	localparam logic [ELEM_W-1:0] ELEM_MAX = 13'd4096;
	localparam logic [DISK_W-1:0] DISKS_RESET = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ELEMENT_SIZE = 2'd0,
		CFG_DATA_DISKS = 2'd1,
		CFG_TOTAL_DISKS = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic kind;
		logic [ADDR_W-1:0] address;
	} in_t;

	typedef struct packed {
		logic status;
		logic [7:0] start_position;
		logic [11:0] offset_in_element;
		logic [12:0] blocks_left_in_element;
		logic [47:0] stripe_start;
		logic [17:0] blocks_left_in_parity;
		logic [10:0] parity_count;
		logic [55:0] mapped_lba;
		logic [7:0] array_width;
	} out_t;

endpackage

[design/rsam_div_cell.sv]
module rsam_div_cell #(
	parameter int N = 48,
	parameter int D = 13,
	parameter int SB_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [D-1:0] divisor,
	input  logic in_valid,
	input  logic [D-1:0] in_rem,
	input  logic [N-1:0] in_quo,
	input  logic [SB_W-1:0] in_sb,
	output logic out_valid,
	output logic [D-1:0] out_rem,
	output logic [N-1:0] out_quo,
	output logic [SB_W-1:0] out_sb
);

	logic [D:0] trial;
	logic [D:0] diff;
	logic fits;
	logic [D-1:0] next_rem;

	// one restoring step: bring down the top dividend bit
	assign trial = {in_rem, in_quo[N-1]};
	assign diff = trial - {1'b0, divisor};
	assign fits = trial >= {1'b0, divisor};
	assign next_rem = fits ? diff[D-1:0] : trial[D-1:0];

	logic valid_q;
	logic [D-1:0] rem_q;
	logic [N-1:0] quo_q;
	logic [SB_W-1:0] sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= next_rem;
			quo_q <= {in_quo[N-2:0], fits};
			sb_q <= in_sb;
		end
	end

	assign out_valid = valid_q;
	assign out_rem = rem_q;
	assign out_quo = quo_q;
	assign out_sb = sb_q;

endmodule

[design/rsam_div_chain.sv]
module rsam_div_chain #(
	parameter int N = 48,
	parameter int D = 13,
	parameter int SB_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [D-1:0] divisor,
	input  logic in_valid,
	input  logic [N-1:0] dividend,
	input  logic [SB_W-1:0] in_sb,
	output logic out_valid,
	output logic [D-1:0] remainder,
	output logic [N-1:0] quotient,
	output logic [SB_W-1:0] out_sb
);

	logic valid_c [0:N];
	logic [D-1:0] rem_c [0:N];
	logic [N-1:0] quo_c [0:N];
	logic [SB_W-1:0] sb_c [0:N];

	assign valid_c[0] = in_valid;
	assign rem_c[0] = '0;
	assign quo_c[0] = dividend;
	assign sb_c[0] = in_sb;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rsam_div_cell #(.N(N), .D(D), .SB_W(SB_W)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.divisor(divisor),
			.in_valid(valid_c[i]),
			.in_rem(rem_c[i]),
			.in_quo(quo_c[i]),
			.in_sb(sb_c[i]),
			.out_valid(valid_c[i+1]),
			.out_rem(rem_c[i+1]),
			.out_quo(quo_c[i+1]),
			.out_sb(sb_c[i+1])
		);
	end

	assign out_valid = valid_c[N];
	assign remainder = rem_c[N];
	assign quotient = quo_c[N];
	assign out_sb = sb_c[N];

endmodule

[design/raid0_stripe_address_map_unit.sv]
// channel  | valid      | stall      | payload
// input    | in_valid   | in_stall   | in_data  (rsam_pkg::in_t)
// output   | out_valid  | out_stall  | out_data (rsam_pkg::out_t)
// config   | cfg_we     | -          | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low
// the pipe is two 48-cell restoring divider chains in series (address by element
// size, then quotient by data disks) plus two multiply stages
// the whole pipe holds while a result waits under out_stall; in_stall mirrors that
// reset empties the pipe and loads the register defaults
module raid0_stripe_address_map_unit #(
	parameter int MAX_WIDTH = rsam_pkg::MAX_WIDTH_DEF,
	parameter int BACKEND_BLOCKS = rsam_pkg::BACKEND_BLOCKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  rsam_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsam_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [rsam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsam_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = rsam_pkg::ADDR_W;
	localparam int EW = rsam_pkg::ELEM_W;
	localparam int DW = rsam_pkg::DISK_W;
	localparam int LW = rsam_pkg::LBA_W;
	localparam logic [AW-1:0] BB_VEC = AW'(BACKEND_BLOCKS);
	localparam int SBB_W = 1 + AW + AW + EW + EW;

	logic [EW-1:0] element_size_q;
	logic [DW-1:0] data_disks_q;
	logic [DW-1:0] total_disks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_size_q <= rsam_pkg::ELEM_RESET;
			data_disks_q <= rsam_pkg::DISKS_RESET;
			total_disks_q <= rsam_pkg::DISKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsam_pkg::CFG_ELEMENT_SIZE: element_size_q <= cfg_data[EW-1:0];
				rsam_pkg::CFG_DATA_DISKS:   data_disks_q <= cfg_data[DW-1:0];
				rsam_pkg::CFG_TOTAL_DISKS:  total_disks_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	logic [EW-1:0] es;
	logic [DW-1:0] dd;

	always_comb begin
		priority if (element_size_q == '0) es = EW'(1);
		else if (element_size_q > rsam_pkg::ELEM_MAX) es = rsam_pkg::ELEM_MAX;
		else es = element_size_q;
	end

	assign dd = (data_disks_q == '0) ? DW'(1) : data_disks_q;

	logic out_valid_q;
	logic en;

	assign en = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// address / element size
	logic va;
	logic [EW-1:0] ra;
	logic [AW-1:0] qa;
	logic phys_a;

	rsam_div_chain #(.N(AW), .D(EW), .SB_W(1)) u_div_elem (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.divisor(es),
		.in_valid(in_valid),
		.dividend(in_data.address),
		.in_sb(in_data.kind),
		.out_valid(va),
		.remainder(ra),
		.quotient(qa),
		.out_sb(phys_a)
	);

	// backend blocks modulo element size, alongside, carrying the address
	logic vc;
	logic [EW-1:0] rc;
	logic [AW-1:0] addr_c;

	rsam_div_chain #(.N(AW), .D(EW), .SB_W(AW)) u_div_backend (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.divisor(es),
		.in_valid(in_valid),
		.dividend(BB_VEC),
		.in_sb(in_data.address),
		.out_valid(vc),
		.remainder(rc),
		.quotient(),
		.out_sb(addr_c)
	);

	// element index / data disks
	logic vb;
	logic [DW-1:0] pb;
	logic [AW-1:0] sb_quo;
	logic [SBB_W-1:0] sbb;
	logic phys_b;
	logic [AW-1:0] addr_b;
	logic [AW-1:0] q_b;
	logic [EW-1:0] r_b;
	logic [EW-1:0] brem_b;

	rsam_div_chain #(.N(AW), .D(DW), .SB_W(SBB_W)) u_div_disks (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.divisor(dd),
		.in_valid(va && vc),
		.dividend(qa),
		.in_sb({phys_a, addr_c, qa, ra, rc}),
		.out_valid(vb),
		.remainder(pb),
		.quotient(sb_quo),
		.out_sb(sbb)
	);

	assign {phys_b, addr_b, q_b, r_b, brem_b} = sbb;

	// physical mode: stripe number is the element index itself
	logic [AW-1:0] stripe_sel;
	logic [AW+EW-1:0] prod_full;

	assign stripe_sel = phys_b ? q_b : sb_quo;
	assign prod_full = (AW + EW)'(stripe_sel) * (AW + EW)'(es);

	logic v_s1;
	logic phys_s1;
	logic [AW-1:0] addr_s1;
	logic [LW-1:0] prod_s1;
	logic [DW-1:0] pos_s1;
	logic [EW-1:0] r_s1;
	logic [EW-1:0] brem_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phys_s1 <= phys_b;
			addr_s1 <= addr_b;
			prod_s1 <= prod_full[LW-1:0];
			pos_s1 <= pb;
			r_s1 <= r_b;
			brem_s1 <= brem_b;
		end
	end

	logic [LW+DW-1:0] phys_lba;
	logic [EW-1:0] left_elem;
	logic [31:0] left_log;
	logic [31:0] par_cnt;
	rsam_pkg::out_t res;

	assign phys_lba = (LW + DW)'(prod_s1) * (LW + DW)'(dd) + (LW + DW)'(r_s1);
	assign left_elem = es - r_s1;
	assign left_log = 32'(dd) * 32'(BACKEND_BLOCKS);
	assign par_cnt = 32'(BACKEND_BLOCKS) - 32'(brem_s1);

	always_comb begin
		res.status = 32'(data_disks_q) > 32'(MAX_WIDTH);
		res.start_position = phys_s1 ? '0 : pos_s1;
		res.offset_in_element = r_s1[11:0];
		res.blocks_left_in_element = left_elem;
		res.stripe_start = prod_s1[AW-1:0];
		res.blocks_left_in_parity = phys_s1 ? 18'(left_elem) : left_log[17:0];
		res.parity_count = par_cnt[10:0];
		res.mapped_lba = phys_s1 ? phys_lba[LW-1:0] : LW'(addr_s1);
		res.array_width = phys_s1 ? total_disks_q : '0;
	end

	rsam_pkg::out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

[test/raid0_stripe_address_map_unit_tb.sv]
module raid0_stripe_address_map_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_LOGICAL = 1'b0;
	localparam logic KIND_PHYSICAL = 1'b1;
	localparam logic [rsam_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PIPE_DEPTH = 2 * 48 + 2;

	typedef struct {
		logic kind;
		logic [rsam_pkg::ADDR_W-1:0] address;
		bit fixed;
		rsam_pkg::out_t result;
	} map_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rsam_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsam_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [rsam_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rsam_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [rsam_pkg::ELEM_W-1:0] elem_reg = rsam_pkg::ELEM_RESET;
	logic [rsam_pkg::DISK_W-1:0] disks_reg = rsam_pkg::DISKS_RESET;
	logic [rsam_pkg::DISK_W-1:0] total_reg = rsam_pkg::DISKS_RESET;

	rsam_pkg::out_t pending_maps[$];
	int errors = 0;
	int cycles = 0;
	bit long_hold = 0;
	map_row_t directed[13];

	raid0_stripe_address_map_unit uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("raid0_stripe_address_map_unit regression: fail");
			$finish;
		end
	end

	function automatic rsam_pkg::out_t map_address(rsam_pkg::in_t req);
		logic [63:0] es, dd, addr, lba, offset;
		rsam_pkg::out_t r;
		es = 64'(elem_reg);
		if (es == 64'd0) es = 64'd1;
		if (es > 64'(rsam_pkg::ELEM_MAX)) es = 64'(rsam_pkg::ELEM_MAX);
		dd = (disks_reg == '0) ? 64'd1 : 64'(disks_reg);
		addr = 64'(req.address);
		lba = (req.kind == KIND_PHYSICAL) ? (addr / es) * es * dd + addr % es : addr;
		offset = lba % es;
		r.status = disks_reg > rsam_pkg::MAX_WIDTH_DEF;
		r.start_position = 8'((lba / es) % dd);
		r.offset_in_element = 12'(offset);
		r.blocks_left_in_element = 13'(es - offset);
		r.stripe_start = 48'((lba / (es * dd)) * es);
		r.blocks_left_in_parity = (req.kind == KIND_PHYSICAL) ? 18'(es - offset)
			: 18'(dd * 64'(rsam_pkg::BACKEND_BLOCKS_DEF));
		r.parity_count = 11'(es * (64'(rsam_pkg::BACKEND_BLOCKS_DEF) / es));
		r.mapped_lba = 56'(lba);
		r.array_width = (req.kind == KIND_PHYSICAL) ? total_reg : 8'd0;
		return r;
	endfunction

	task automatic issue(logic kind, logic [rsam_pkg::ADDR_W-1:0] address, bit fixed,
		rsam_pkg::out_t result);
		rsam_pkg::in_t req;
		req.kind = kind;
		req.address = address;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		pending_maps.push_back(fixed ? result : map_address(req));
	endtask

	task automatic pause_sender(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic write_reg(logic [rsam_pkg::CFG_IDX_W-1:0] idx,
		logic [rsam_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			rsam_pkg::CFG_ELEMENT_SIZE: elem_reg = value;
			rsam_pkg::CFG_DATA_DISKS: disks_reg = value[rsam_pkg::DISK_W-1:0];
			rsam_pkg::CFG_TOTAL_DISKS: total_reg = value[rsam_pkg::DISK_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [rsam_pkg::ADDR_W-1:0] pick_address();
		int r;
		logic [63:0] es;
		r = $urandom_range(0, 99);
		es = (elem_reg == '0) ? 64'd1 : (elem_reg > rsam_pkg::ELEM_MAX
			? 64'(rsam_pkg::ELEM_MAX) : 64'(elem_reg));
		if (r < 40) return 48'({$urandom, $urandom});
		if (r < 60) return 48'($urandom_range(0, 20000));
		if (r < 70) return ~48'($urandom_range(0, 5000));
		// element boundaries
		return 48'(64'($urandom_range(0, 100000)) * es
			+ ($urandom_range(0, 1) ? es - 64'd1 : 64'd0));
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $realtime, name, exp_v, act_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rsam_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_maps.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none actual %0h", $realtime,
					out_data);
			end else begin
				e = pending_maps.pop_front();
				check_field("status", 64'(e.status), 64'(out_data.status));
				check_field("start_position", 64'(e.start_position),
					64'(out_data.start_position));
				check_field("offset_in_element", 64'(e.offset_in_element),
					64'(out_data.offset_in_element));
				check_field("blocks_left_in_element", 64'(e.blocks_left_in_element),
					64'(out_data.blocks_left_in_element));
				check_field("stripe_start", 64'(e.stripe_start), 64'(out_data.stripe_start));
				check_field("blocks_left_in_parity", 64'(e.blocks_left_in_parity),
					64'(out_data.blocks_left_in_parity));
				check_field("parity_count", 64'(e.parity_count), 64'(out_data.parity_count));
				check_field("mapped_lba", 64'(e.mapped_lba), 64'(out_data.mapped_lba));
				check_field("array_width", 64'(e.array_width), 64'(out_data.array_width));
			end
		end
	end

	// receiver back-pressure
	initial begin
		int r, n;
		logic v;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 0;
				repeat (3 * PIPE_DEPTH) @(negedge clk) out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				v = (r >= 50);
				n = (r < 50) ? $urandom_range(1, 20) : (r < 95 ? $urandom_range(1, 3)
					: $urandom_range(10, 40));
				repeat (n) @(negedge clk) out_stall <= v;
			end
		end
	end

	initial begin
		int r, count;
		logic [rsam_pkg::CFG_DATA_W-1:0] setups[10][3];
		directed = '{
			'{KIND_LOGICAL, 48'd0, 1, '{1'b0, 8'd0, 12'd0, 13'd128, 48'd0, 18'd4096, 11'd1024,
				56'd0, 8'd0}},
			'{KIND_PHYSICAL, 48'd0, 1, '{1'b0, 8'd0, 12'd0, 13'd128, 48'd0, 18'd128, 11'd1024,
				56'd0, 8'd4}},
			'{KIND_LOGICAL, 48'd127, 1, '{1'b0, 8'd0, 12'd127, 13'd1, 48'd0, 18'd4096,
				11'd1024, 56'd127, 8'd0}},
			'{KIND_LOGICAL, 48'd128, 1, '{1'b0, 8'd1, 12'd0, 13'd128, 48'd0, 18'd4096,
				11'd1024, 56'd128, 8'd0}},
			'{KIND_LOGICAL, 48'd512, 1, '{1'b0, 8'd0, 12'd0, 13'd128, 48'd128, 18'd4096,
				11'd1024, 56'd512, 8'd0}},
			'{KIND_PHYSICAL, 48'd127, 0, '0},
			'{KIND_PHYSICAL, 48'd128, 0, '0},
			'{KIND_LOGICAL, 48'hFFFF_FFFF_FFFF, 0, '0},
			'{KIND_PHYSICAL, 48'hFFFF_FFFF_FFFF, 0, '0},
			'{KIND_LOGICAL, 48'h5555_5555_5555, 0, '0},
			'{KIND_PHYSICAL, 48'hAAAA_AAAA_AAAA, 0, '0},
			'{KIND_PHYSICAL, 48'h5555_5555_5555, 0, '0},
			'{KIND_LOGICAL, 48'hAAAA_AAAA_AAAA, 0, '0}
		};
		// element size, data disks, total disks; zero and oversize element sizes and zero data disks get clamped
		setups = '{
			'{13'd128, 13'd4, 13'd4}, '{13'd1, 13'd1, 13'd1}, '{13'd4096, 13'd255, 13'd255},
			'{13'd0, 13'd0, 13'd0}, '{13'd8191, 13'd16, 13'd17}, '{13'd4097, 13'd17, 13'd255},
			'{13'd7, 13'd3, 13'd5}, '{13'd100, 13'h1C8, 13'd8}, '{13'd0, 13'd0, 13'd0},
			'{13'd0, 13'd0, 13'd0}};
		for (int p = 8; p < 10; p++) begin
			setups[p][0] = $urandom_range(0, 9) == 0 ? 13'($urandom)
				: 13'($urandom_range(1, 4096));
			setups[p][1] = 13'($urandom_range(1, 20));
			setups[p][2] = 13'($urandom_range(0, 255));
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			issue(directed[i].kind, directed[i].address, directed[i].fixed, directed[i].result);

		for (int p = 0; p < 10; p++) begin
			pause_sender(1);
			wait (pending_maps.size() == 0);
			write_reg(rsam_pkg::CFG_ELEMENT_SIZE, setups[p][0]);
			write_reg(rsam_pkg::CFG_DATA_DISKS, setups[p][1]);
			write_reg(rsam_pkg::CFG_TOTAL_DISKS, setups[p][2]);
			if (p == 3) write_reg(CFG_UNUSED, 13'($urandom));
			count = (p == 2) ? 200 : 55;
			for (int i = 0; i < count; i++) begin
				// fill the pipe while the receiver holds off
				if (p == 2 && i == 10) long_hold = 1;
				issue(1'($urandom_range(0, 1)), pick_address(), 0, '0);
				r = $urandom_range(0, 99);
				if (p == 2 && i < 150) r = 0;
				if (r >= 60) pause_sender(r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30));
			end
		end
		pause_sender(1);
		wait (pending_maps.size() == 0);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (errors == 0)
			$display("raid0_stripe_address_map_unit regression: pass");
		else
			$display("raid0_stripe_address_map_unit regression: fail");
		$finish;
	end

endmodule
